// ----- hw/rtl/mtc_pkg.sv -----
package mtc_pkg;

    // fixed field widths of the transfer payloads
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;
    localparam int CH_MAX = 4;

    // defaults for the top-level parameters
    localparam int DEF_COUNTER_WIDTH  = 32;
    localparam int DEF_MATCH_CHANNELS = 4;

    // per-channel layout of the match control register
    localparam int MCR_BITS  = 3;
    localparam int MCR_INT   = 0;
    localparam int MCR_RESET = 1;
    localparam int MCR_STOP  = 2;

    // register map
    localparam logic [ADDR_W-1:0] ADDR_FLAGS    = 4'd0;
    localparam logic [ADDR_W-1:0] ADDR_CONTROL  = 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_COUNT    = 4'd2;
    localparam logic [ADDR_W-1:0] ADDR_PRESCALE = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_PCOUNT   = 4'd4;
    localparam logic [ADDR_W-1:0] ADDR_MCR      = 4'd5;
    localparam logic [ADDR_W-1:0] ADDR_MATCH0   = 4'd6;
    localparam logic [ADDR_W-1:0] ADDR_MATCH1   = 4'd7;
    localparam logic [ADDR_W-1:0] ADDR_MATCH2   = 4'd8;
    localparam logic [ADDR_W-1:0] ADDR_MATCH3   = 4'd9;
    localparam logic [ADDR_W-1:0] ADDR_PWM_EN   = 4'd10;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   reg_addr;
        logic [DATA_W-1:0]   write_data;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic                irq;
        logic [CH_MAX-1:0]   match_flags;
        logic [CH_MAX-1:0]   pwm_levels;
        logic                running;
    } t_result;

endpackage

// ----- hw/rtl/mtc_in_reg.sv -----
module mtc_in_reg
    import mtc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_stall,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // hold off the sender only while a held item is not being taken
    assign o_stall = r_valid && !i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // capture payload on an input transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- hw/rtl/mtc_core.sv -----
module mtc_core
    import mtc_pkg::*;
#(
    parameter int COUNTER_WIDTH  = DEF_COUNTER_WIDTH,
    parameter int MATCH_CHANNELS = DEF_MATCH_CHANNELS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam int W = COUNTER_WIDTH;
    localparam int N = MATCH_CHANNELS;

    logic [W-1:0]       r_count, n_count;
    logic [W-1:0]       r_plimit, n_plimit;
    logic [W-1:0]       r_pcount, n_pcount;
    logic               r_enable, n_enable;
    logic [MCR_BITS*N-1:0] r_mcr, n_mcr;
    logic [W-1:0]       r_match [N];
    logic [W-1:0]       n_match [N];
    logic [N-1:0]       r_flags, n_flags;
    logic [N-1:0]       r_pwm_en, n_pwm_en;

    logic               presc_hit;
    logic               wrap;
    logic [W-1:0]       cnt_tick;
    logic [N-1:0]       eq_new;
    logic [N-1:0]       int_sel;
    logic [N-1:0]       stop_sel;
    logic [DATA_W-1:0]  rd;
    logic [N-1:0]       pwm;

    // tick datapath: prescale compare, reset-on-match, event detect
    always_comb begin
        presc_hit = !(r_pcount < r_plimit);
        wrap      = 1'b0;
        for (int c = 0; c < N; c++) begin
            if (r_mcr[MCR_BITS*c+MCR_RESET] && (r_count == r_match[c])) begin
                wrap = 1'b1;
            end
        end
        cnt_tick = wrap ? '0 : r_count + W'(1);
        for (int c = 0; c < N; c++) begin
            eq_new[c]   = (cnt_tick == r_match[c]);
            int_sel[c]  = r_mcr[MCR_BITS*c+MCR_INT];
            stop_sel[c] = r_mcr[MCR_BITS*c+MCR_STOP];
        end
    end

    // next state and read data for one item
    always_comb begin
        n_count  = r_count;
        n_plimit = r_plimit;
        n_pcount = r_pcount;
        n_enable = r_enable;
        n_mcr    = r_mcr;
        n_match  = r_match;
        n_flags  = r_flags;
        n_pwm_en = r_pwm_en;
        rd       = '0;
        case (i_item.opcode)
            OP_TICK: begin
                if (r_enable) begin
                    if (!presc_hit) begin
                        n_pcount = r_pcount + W'(1);
                    end else begin
                        n_pcount = '0;
                        n_count  = cnt_tick;
                        n_flags  = r_flags | (eq_new & int_sel);
                        if ((eq_new & stop_sel) != '0) begin
                            n_enable = 1'b0;
                        end
                    end
                end
            end
            OP_READ: begin
                unique case (i_item.reg_addr) inside
                    ADDR_FLAGS:    rd = DATA_W'(r_flags);
                    ADDR_CONTROL:  rd = DATA_W'(r_enable);
                    ADDR_COUNT:    rd = DATA_W'(r_count);
                    ADDR_PRESCALE: rd = DATA_W'(r_plimit);
                    ADDR_PCOUNT:   rd = DATA_W'(r_pcount);
                    ADDR_MCR:      rd = DATA_W'(r_mcr);
                    ADDR_MATCH0, ADDR_MATCH1, ADDR_MATCH2, ADDR_MATCH3: begin
                        for (int c = 0; c < N; c++) begin
                            if (i_item.reg_addr == ADDR_MATCH0 + ADDR_W'(c)) begin
                                rd = DATA_W'(r_match[c]);
                            end
                        end
                    end
                    ADDR_PWM_EN:   rd = DATA_W'(r_pwm_en);
                    default:       rd = '0;
                endcase
            end
            OP_WRITE: begin
                unique case (i_item.reg_addr) inside
                    ADDR_FLAGS:    n_flags  = r_flags & ~i_item.write_data[N-1:0];
                    ADDR_CONTROL:  n_enable = i_item.write_data[0];
                    ADDR_COUNT:    n_count  = i_item.write_data[W-1:0];
                    ADDR_PRESCALE: n_plimit = i_item.write_data[W-1:0];
                    ADDR_PCOUNT:   n_pcount = i_item.write_data[W-1:0];
                    ADDR_MCR:      n_mcr    = i_item.write_data[MCR_BITS*N-1:0];
                    ADDR_MATCH0, ADDR_MATCH1, ADDR_MATCH2, ADDR_MATCH3: begin
                        for (int c = 0; c < N; c++) begin
                            if (i_item.reg_addr == ADDR_MATCH0 + ADDR_W'(c)) begin
                                n_match[c] = i_item.write_data[W-1:0];
                            end
                        end
                    end
                    ADDR_PWM_EN:   n_pwm_en = i_item.write_data[N-1:0];
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // pwm levels from the state after the step
    always_comb begin
        for (int c = 0; c < N; c++) begin
            pwm[c] = n_pwm_en[c] && (n_count >= n_match[c]);
        end
    end

    // result for the output register
    always_comb begin
        o_result.read_data   = rd;
        o_result.irq         = (n_flags != '0);
        o_result.match_flags = CH_MAX'(n_flags);
        o_result.pwm_levels  = CH_MAX'(pwm);
        o_result.running     = n_enable;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_plimit <= '0;
            r_pcount <= '0;
            r_enable <= 1'b0;
            r_mcr    <= '0;
            r_flags  <= '0;
            r_pwm_en <= '0;
            for (int c = 0; c < N; c++) begin
                r_match[c] <= '0;
            end
        end else if (i_step) begin
            r_count  <= n_count;
            r_plimit <= n_plimit;
            r_pcount <= n_pcount;
            r_enable <= n_enable;
            r_mcr    <= n_mcr;
            r_flags  <= n_flags;
            r_pwm_en <= n_pwm_en;
            r_match  <= n_match;
        end
    end

endmodule

// ----- hw/rtl/mtc_out_reg.sv -----
module mtc_out_reg
    import mtc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or when the held result goes out this cycle
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_ready) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ----- hw/rtl/match_timer_counter.sv -----
// an item is held in the input register and its result in the output register before it goes out
// throughput: one item per cycle while the receiver does not stall the output; the core updates its state per item
// an input register and an output register decouple the two channels
// reset: synchronous, active low; clears all timer state and both valid flags
module match_timer_counter
    import mtc_pkg::*;
#(
    parameter int COUNTER_WIDTH  = DEF_COUNTER_WIDTH,
    parameter int MATCH_CHANNELS = DEF_MATCH_CHANNELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_reg_addr,
    input  logic [DATA_W-1:0] i_write_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_read_data,
    output logic              o_irq,
    output logic [CH_MAX-1:0] o_match_flags,
    output logic [CH_MAX-1:0] o_pwm_levels,
    output logic              o_running
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    out_ready;
    logic    step;
    t_result core_result;
    t_result out_result;

    // pack the input fields
    always_comb begin
        in_item.opcode     = t_opcode'(i_opcode);
        in_item.reg_addr   = i_reg_addr;
        in_item.write_data = i_write_data;
    end

    // one item is processed whenever the output register can take its result
    assign step = held_valid && out_ready;

    mtc_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (in_item),
        .i_take  (step),
        .o_stall (o_stall),
        .o_valid (held_valid),
        .o_item  (held_item)
    );

    mtc_core #(
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .MATCH_CHANNELS (MATCH_CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (core_result)
    );

    mtc_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_stall  (i_stall),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .o_result (out_result)
    );

    // unpack the result fields
    assign o_read_data   = out_result.read_data;
    assign o_irq         = out_result.irq;
    assign o_match_flags = out_result.match_flags;
    assign o_pwm_levels  = out_result.pwm_levels;
    assign o_running     = out_result.running;

`ifndef SYNTH
    // no result is presented straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // interrupt line follows the pending flags of the same result
    a_irq_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_irq == (o_match_flags != '0)))
        else $error("irq does not match pending flags");

    // absent channels never raise a flag
    a_flags_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_match_flags >> MATCH_CHANNELS) == '0))
        else $error("flag set on an absent channel");

    // absent channels never drive a pwm level
    a_pwm_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_pwm_levels >> MATCH_CHANNELS) == '0))
        else $error("pwm level on an absent channel");
`endif

endmodule

// ----- tb/sv/tb_match_timer_counter.sv -----
module tb_match_timer_counter
    import mtc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // codes outside the package's opcode enum and register map
    localparam logic [1:0]        OP_UNUSED      = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED_LO = ADDR_PWM_EN + 4'd1;
    localparam logic [ADDR_W-1:0] ADDR_UNUSED_HI = 4'd15;

    localparam int MCR_W    = MCR_BITS * CH_MAX;
    localparam int CH_IDX_W = $clog2(CH_MAX);

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              o_stall;
    logic [1:0]        i_opcode     = '0;
    logic [ADDR_W-1:0] i_reg_addr   = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              o_valid;
    logic              i_stall      = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_irq;
    logic [CH_MAX-1:0] o_match_flags;
    logic [CH_MAX-1:0] o_pwm_levels;
    logic              o_running;

    // timer state as the testbench sees it
    logic [DATA_W-1:0] cnt_val   = '0;
    logic [DATA_W-1:0] psc_lim   = '0;
    logic [DATA_W-1:0] psc_cnt   = '0;
    logic              run_en    = 1'b0;
    logic [MCR_W-1:0]  mcr       = '0;
    logic [DATA_W-1:0] match_val [CH_MAX] = '{default: '0};
    logic [CH_MAX-1:0] flags     = '0;
    logic [CH_MAX-1:0] pwm_en    = '0;

    t_result predicted_status [$];

    int errors        = 0;
    int items_sent    = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    match_timer_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_data   (o_read_data),
        .o_irq         (o_irq),
        .o_match_flags (o_match_flags),
        .o_pwm_levels  (o_pwm_levels),
        .o_running     (o_running)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // apply one item to the timer state and work out the status it returns
    function automatic t_result apply_to_timer(input logic [1:0] op,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] data);
        t_result res;
        logic    wrap;
        res  = '0;
        wrap = 1'b0;
        case (op)
            OP_TICK: begin
                if (run_en) begin
                    if (psc_cnt < psc_lim) begin
                        psc_cnt = psc_cnt + 1'b1;
                    end else begin
                        psc_cnt = '0;
                        for (int c = 0; c < CH_MAX; c++)
                            if (mcr[c*MCR_BITS + MCR_RESET] && cnt_val == match_val[c])
                                wrap = 1'b1;
                        cnt_val = wrap ? '0 : cnt_val + 1'b1;
                        // match events only come from ticks
                        for (int c = 0; c < CH_MAX; c++) begin
                            if (cnt_val == match_val[c]) begin
                                if (mcr[c*MCR_BITS + MCR_INT])
                                    flags[c] = 1'b1;
                                if (mcr[c*MCR_BITS + MCR_STOP])
                                    run_en = 1'b0;
                            end
                        end
                    end
                end
            end
            OP_READ: begin
                case (addr)
                    ADDR_FLAGS:    res.read_data = DATA_W'(flags);
                    ADDR_CONTROL:  res.read_data = DATA_W'(run_en);
                    ADDR_COUNT:    res.read_data = cnt_val;
                    ADDR_PRESCALE: res.read_data = psc_lim;
                    ADDR_PCOUNT:   res.read_data = psc_cnt;
                    ADDR_MCR:      res.read_data = DATA_W'(mcr);
                    ADDR_MATCH0, ADDR_MATCH1, ADDR_MATCH2, ADDR_MATCH3:
                        res.read_data = match_val[CH_IDX_W'(addr - ADDR_MATCH0)];
                    ADDR_PWM_EN:   res.read_data = DATA_W'(pwm_en);
                    default:       res.read_data = '0;
                endcase
            end
            OP_WRITE: begin
                case (addr)
                    ADDR_FLAGS:    flags   = flags & ~data[CH_MAX-1:0];
                    ADDR_CONTROL:  run_en  = data[0];
                    ADDR_COUNT:    cnt_val = data;
                    ADDR_PRESCALE: psc_lim = data;
                    ADDR_PCOUNT:   psc_cnt = data;
                    ADDR_MCR:      mcr     = data[MCR_W-1:0];
                    ADDR_MATCH0, ADDR_MATCH1, ADDR_MATCH2, ADDR_MATCH3:
                        match_val[CH_IDX_W'(addr - ADDR_MATCH0)] = data;
                    ADDR_PWM_EN:   pwm_en  = data[CH_MAX-1:0];
                    default: ;
                endcase
            end
            default: ;
        endcase
        for (int c = 0; c < CH_MAX; c++)
            res.pwm_levels[c] = pwm_en[c] && (cnt_val >= match_val[c]);
        res.irq         = |flags;
        res.match_flags = flags;
        res.running     = run_en;
        return res;
    endfunction

    function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
                                          input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_opcode     <= op;
        i_reg_addr   <= addr;
        i_write_data <= data;
        i_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predicted_status.push_back(apply_to_timer(op, addr, data));
        items_sent++;
    endtask

    task automatic send_noise_item();
        send_item(2'($urandom_range(3)), ADDR_W'($urandom_range(ADDR_UNUSED_HI)), $urandom);
    endtask

    // sender pauses until every status has come back
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (predicted_status.size() != 0) @(posedge i_clk);
    endtask

    // register map extremes and the corner cases of counting
    task automatic test_directed_cases();
        send_item(OP_READ, ADDR_COUNT, '0);
        send_item(OP_UNUSED, ADDR_UNUSED_HI, '1);
        send_item(OP_WRITE, ADDR_UNUSED_HI, '1);
        send_item(OP_READ, ADDR_UNUSED_HI, '0);
        send_item(OP_TICK, '0, '0);
        // top of the count range, all channel actions on
        send_item(OP_WRITE, ADDR_MATCH0, '1);
        send_item(OP_WRITE, ADDR_COUNT, 32'hffff_fffe);
        send_item(OP_WRITE, ADDR_MCR, '1);
        send_item(OP_WRITE, ADDR_PWM_EN, '1);
        send_item(OP_WRITE, ADDR_CONTROL, '1);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        // reset on match, then the other channels match at zero
        send_item(OP_WRITE, ADDR_CONTROL, 32'h1);
        send_item(OP_TICK, '0, '0);
        send_item(OP_WRITE, ADDR_FLAGS, 32'h5);
        send_item(OP_READ, ADDR_FLAGS, '0);
        // a count write equal to a match raises nothing
        send_item(OP_WRITE, ADDR_FLAGS, '1);
        send_item(OP_WRITE, ADDR_COUNT, '1);
        send_item(OP_READ, ADDR_FLAGS, '0);
        // prescale count above limit, then a plain wrap of the count
        send_item(OP_WRITE, ADDR_PRESCALE, 32'h2);
        send_item(OP_WRITE, ADDR_PCOUNT, '1);
        send_item(OP_WRITE, ADDR_MCR, '0);
        send_item(OP_WRITE, ADDR_CONTROL, 32'h1);
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_READ, ADDR_PCOUNT, '0);
    endtask

    // program the channels, start the timer and let it run
    task automatic run_match_scenario();
        logic [DATA_W-1:0] base;
        int                n_steps;
        int                pick;
        base    = ($urandom_range(9) == 0) ? 32'hffff_ffe0 : '0;
        n_steps = $urandom_range(40, 10);
        for (int c = 0; c < CH_MAX; c++)
            send_item(OP_WRITE, ADDR_W'(ADDR_MATCH0 + c), base + $urandom_range(40));
        send_item(OP_WRITE, ADDR_PRESCALE,
                  ($urandom_range(3) == 0) ? DATA_W'($urandom_range(3)) : '0);
        if ($urandom_range(4) == 0)
            send_item(OP_WRITE, ADDR_PCOUNT, $urandom);
        send_item(OP_WRITE, ADDR_MCR, $urandom);
        send_item(OP_WRITE, ADDR_PWM_EN, $urandom);
        send_item(OP_WRITE, ADDR_COUNT, base + $urandom_range(10));
        send_item(OP_WRITE, ADDR_CONTROL, ($urandom_range(7) == 0) ? $urandom : 32'h1);
        repeat (n_steps) begin
            pick = $urandom_range(99);
            if (pick < 65)
                send_item(OP_TICK, ADDR_W'($urandom), $urandom);
            else if (pick < 75)
                send_item(OP_READ, ADDR_W'($urandom_range(ADDR_UNUSED_HI)), $urandom);
            else if (pick < 82)
                send_item(OP_WRITE, ADDR_FLAGS, $urandom);
            else if (pick < 86)
                send_item(OP_WRITE, ADDR_CONTROL, 32'h1);
            else if (pick < 90)
                send_item(OP_WRITE, ADDR_W'($urandom_range(ADDR_MATCH3, ADDR_COUNT)),
                          base + $urandom_range(40));
            else if (pick < 93)
                send_item(OP_WRITE, ADDR_W'($urandom_range(ADDR_UNUSED_HI, ADDR_UNUSED_LO)),
                          $urandom);
            else
                send_noise_item();
        end
    endtask

    // mostly programmed runs, some raw noise in between
    task automatic test_random_traffic(input int n_items);
        int first;
        first = items_sent;
        while (items_sent - first < n_items) begin
            if ($urandom_range(9) < 8)
                run_match_scenario();
            else
                repeat ($urandom_range(8, 1)) send_noise_item();
        end
        wait_for_results();
    endtask

    // long receiver hold-off while the sender keeps offering
    task automatic test_output_backpressure();
        hold_requests++;
        send_item(OP_WRITE, ADDR_PRESCALE, '0);
        send_item(OP_WRITE, ADDR_CONTROL, 32'h1);
        repeat (60) begin
            if ($urandom_range(3) == 0)
                send_item(OP_READ, ADDR_W'($urandom_range(ADDR_UNUSED_HI)), $urandom);
            else
                send_item(OP_TICK, '0, $urandom);
        end
        wait_for_results();
    endtask

    // receiver stall: random, or held for a long stretch on request
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // check each output transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (predicted_status.size() == 0) begin
                $error("status transfer with no item outstanding");
                errors++;
            end else begin
                want = predicted_status.pop_front();
                compare_field("read_data", want.read_data, o_read_data);
                compare_field("irq", DATA_W'(want.irq), DATA_W'(o_irq));
                compare_field("match_flags", DATA_W'(want.match_flags), DATA_W'(o_match_flags));
                compare_field("pwm_levels", DATA_W'(want.pwm_levels), DATA_W'(o_pwm_levels));
                compare_field("running", DATA_W'(want.running), DATA_W'(o_running));
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 70;
        test_directed_cases();
        test_random_traffic(560);

        send_idle_pct = 70;
        recv_idle_pct = 29;
        test_random_traffic(560);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(560);
        test_output_backpressure();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
